>>> sv/rif_pkg.sv
`timescale 1ns / 1ps
package rif_pkg;

	localparam int MAX_RADIX  = 16;
	localparam int MAX_DIGITS = 32;
	localparam int NUM_SYMS   = 16;
	localparam int DIG_W      = $clog2(MAX_RADIX);
	localparam int IDX_W      = $clog2(MAX_DIGITS);
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
	localparam int BIT_W      = 5;
	localparam int VAL_W      = 32;
	localparam int LEN_W      = 5;
	localparam int SYM_W      = 8;
	localparam int DATA_W     = 64;
	localparam int ADDR_W     = 5;

	localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

	localparam logic [1:0] REG_BASE_LEN = 2'd0;
	localparam logic [1:0] REG_ALPHA_LO = 2'd1;
	localparam logic [1:0] REG_ALPHA_HI = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_NEXT,
		ST_SIGN,
		ST_EMIT
	} rif_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic store;
		logic sign;
		logic rd;
	} rif_cmd_t;

	typedef struct packed {
		logic alpha_ok;
		logic bit_last;
		logic more;
		logic neg;
		logic emit_last;
	} rif_status_t;

endpackage

>>> sv/rif_ctrl.sv
`timescale 1ns / 1ps
module rif_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  rif_pkg::rif_status_t sts,
	output rif_pkg::rif_cmd_t    cmd,
	output logic                busy
);
	import rif_pkg::*;

	rif_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && sts.alpha_ok) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.bit_last) state_d = ST_NEXT;
			end
			ST_NEXT: begin
				if (sts.more) state_d = ST_DIV;
				else if (sts.neg) state_d = ST_SIGN;
				else state_d = ST_EMIT;
			end
			ST_SIGN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.emit_last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start && sts.alpha_ok;
			end
			ST_DIV:  cmd.step  = 1'b1;
			ST_NEXT: cmd.store = 1'b1;
			ST_SIGN: cmd.sign  = 1'b1;
			ST_EMIT: cmd.rd    = 1'b1;
			default: busy = 1'b0;
		endcase
	end

endmodule

>>> sv/rif_datapath.sv
`timescale 1ns / 1ps
module rif_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [rif_pkg::VAL_W-1:0] value,
	input  logic [rif_pkg::LEN_W-1:0]    base_length,
	input  logic [rif_pkg::DATA_W-1:0]   alphabet_low,
	input  logic [rif_pkg::DATA_W-1:0]   alphabet_high,
	input  rif_pkg::rif_cmd_t            cmd,
	output rif_pkg::rif_status_t         sts,
	output logic                         strobe,
	output logic [rif_pkg::SYM_W-1:0]    symbol,
	output logic                         last
);
	import rif_pkg::*;

	function automatic logic [SYM_W-1:0] sym_at(input logic [DATA_W-1:0] lo,
		input logic [DATA_W-1:0] hi, input logic [DIG_W-1:0] k);
		logic [DATA_W-1:0] word;
		word = k[DIG_W-1] ? hi : lo;
		return word[{k[DIG_W-2:0], 3'b000} +: SYM_W];
	endfunction

	logic [DIG_W-1:0] digit_mem [MAX_DIGITS];

	logic [VAL_W-1:0] a_q;
	logic [DIG_W-1:0] r_q;
	logic [BIT_W-1:0] bit_q;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] e_q;
	logic             neg_q;
	logic [DIG_W-1:0] rd_s1;
	logic             vld_s1;
	logic             last_s1;
	logic             strobe_q;
	logic [SYM_W-1:0] symbol_q;
	logic             last_q;

	logic [VAL_W-1:0] value_u;
	logic [DIG_W:0]   trial;
	logic             ge;
	logic [CNT_W-1:0] e_dec;
	logic             alpha_ok;

	assign value_u = value;
	assign trial   = {r_q, a_q[VAL_W-1]};
	assign ge      = trial >= base_length;
	assign e_dec   = e_q - CNT_W'(1);

	always_comb begin
		logic [SYM_W-1:0] sa;
		alpha_ok = (base_length >= LEN_W'(2)) && (base_length <= LEN_W'(MAX_RADIX));
		for (int a = 0; a < NUM_SYMS; a++) begin
			sa = sym_at(alphabet_low, alphabet_high, DIG_W'(a));
			if (LEN_W'(a) < base_length && (sa == SYM_PLUS || sa == SYM_MINUS))
				alpha_ok = 1'b0;
			for (int b = a + 1; b < NUM_SYMS; b++) begin
				if (LEN_W'(b) < base_length
					&& sym_at(alphabet_low, alphabet_high, DIG_W'(b)) == sa)
					alpha_ok = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= value_u[VAL_W-1] ? VAL_W'(0) - value_u : value_u;
			r_q <= '0;
		end else if (cmd.step) begin
			a_q <= {a_q[VAL_W-2:0], ge};
			r_q <= ge ? DIG_W'(trial - (DIG_W+1)'(base_length)) : DIG_W'(trial);
		end else if (cmd.store) begin
			r_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q   <= '0;
			total_q <= '0;
			e_q     <= '0;
			neg_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				bit_q   <= '0;
				total_q <= '0;
				neg_q   <= value_u[VAL_W-1];
			end else if (cmd.step) begin
				bit_q <= bit_q + BIT_W'(1);
			end else if (cmd.store) begin
				bit_q   <= '0;
				total_q <= total_q + CNT_W'(1);
				e_q     <= total_q + CNT_W'(1);
			end else if (cmd.rd) begin
				e_q <= e_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) digit_mem[total_q[IDX_W-1:0]] <= r_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_s1   <= digit_mem[e_dec[IDX_W-1:0]];
			last_s1 <= (e_q == CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			vld_s1   <= cmd.rd;
			strobe_q <= cmd.sign || vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sign) begin
			symbol_q <= SYM_MINUS;
			last_q   <= 1'b0;
		end else begin
			symbol_q <= sym_at(alphabet_low, alphabet_high, rd_s1);
			last_q   <= last_s1;
		end
	end

	assign sts.alpha_ok  = alpha_ok;
	assign sts.bit_last  = (bit_q == BIT_W'(VAL_W - 1));
	assign sts.more      = (a_q != '0) && (total_q < CNT_W'(MAX_DIGITS - 1));
	assign sts.neg       = neg_q;
	assign sts.emit_last = (e_q == CNT_W'(1));

	assign strobe = strobe_q;
	assign symbol = symbol_q;
	assign last   = last_q;

endmodule

>>> sv/radix_integer_formatter_unit.sv
`timescale 1ns / 1ps
// Signed 32-bit integer to text in a configurable radix.
// Config: APB registers, 64-bit data, at byte addresses 0x00 (base_length,
// bits 4:0), 0x08 (alphabet symbols 0-7) and 0x10 (alphabet symbols 8-15).
// pready is tied high; write only while busy is low and output has drained.
// Input: a transaction is taken when start is high and busy is low.
// Output: one alphabet symbol per cycle of strobe, most significant digit first,
// a leading '-' for negatives, last marks the final symbol. The receiver
// cannot stall; each symbol stands for exactly one cycle.
// An invalid alphabet (length below 2 or above 16, a repeated symbol, or a
// '+' or '-' among the used symbols) gives no output and busy stays low.
// Each digit comes from a bit-serial restoring divider: shift/subtract steps,
// then one digit store. Busy covers the division, the sign of a negative
// value and the read-out of the digits; the last symbol leaves after busy
// falls. Worst case (-2^31 in radix 2): D = 32 digits.
// Reset: asynchronous, clears the configuration registers to 0 (invalid alphabet) and
// returns the controller to idle.
module radix_integer_formatter_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [rif_pkg::VAL_W-1:0] value,
	output logic                             strobe,
	output logic [rif_pkg::SYM_W-1:0]        symbol,
	output logic                             last,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rif_pkg::ADDR_W-1:0]       paddr,
	input  logic [rif_pkg::DATA_W-1:0]       pwdata,
	output logic [rif_pkg::DATA_W-1:0]       prdata,
	output logic                             pready
);
	import rif_pkg::*;

	logic [LEN_W-1:0]  base_length_q;
	logic [DATA_W-1:0] alpha_lo_q;
	logic [DATA_W-1:0] alpha_hi_q;
	logic              wr_en;
	logic [1:0]        reg_idx;
	rif_cmd_t          cmd;
	rif_status_t       sts;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_length_q <= '0;
			alpha_lo_q    <= '0;
			alpha_hi_q    <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_BASE_LEN: base_length_q <= pwdata[LEN_W-1:0];
				REG_ALPHA_LO: alpha_lo_q    <= pwdata;
				REG_ALPHA_HI: alpha_hi_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BASE_LEN: prdata = DATA_W'(base_length_q);
			REG_ALPHA_LO: prdata = alpha_lo_q;
			REG_ALPHA_HI: prdata = alpha_hi_q;
			default:      prdata = '0;
		endcase
	end

	rif_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	rif_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.value         (value),
		.base_length   (base_length_q),
		.alphabet_low  (alpha_lo_q),
		.alphabet_high (alpha_hi_q),
		.cmd           (cmd),
		.sts           (sts),
		.strobe        (strobe),
		.symbol        (symbol),
		.last          (last)
	);

endmodule

>>> sv/rif_checker.sv
`timescale 1ns / 1ps
module rif_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      strobe,
	input logic [rif_pkg::SYM_W-1:0] symbol,
	input logic                      last
);
	import rif_pkg::*;

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("symbol right after end of transaction");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && symbol == SYM_MINUS |-> !last)
		else $error("sign marked as final symbol");

	a_strobe_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy) || $past(busy, 2))
		else $error("symbol without a transaction in progress");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without start");

endmodule

bind radix_integer_formatter_unit rif_checker u_rif_checker (.*);

>>> bench/radix_integer_formatter_unit_test.sv
`timescale 1ns / 1ps
module radix_integer_formatter_unit_test;
	import rif_pkg::*;

	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int DRAIN_CYCLES = 8;
	localparam int NUMBER_GOAL  = 410;

	localparam logic [DATA_W-1:0] DEC_LO = 64'h3736_3534_3332_3130;
	localparam logic [DATA_W-1:0] DEC_HI = 64'h0000_0000_0000_3938;
	localparam logic [DATA_W-1:0] HEX_HI = 64'h4645_4443_4241_3938;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             last;
	} glyph_t;

	typedef enum logic {ROW_WRITE, ROW_FORMAT} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [1:0]        sel;
		logic [DATA_W-1:0] data;
		bit                typed;
		string             text;
	} row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic signed [VAL_W-1:0]  value;
	logic                     strobe;
	logic [SYM_W-1:0]         symbol;
	logic                     last;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [ADDR_W-1:0]        paddr;
	logic [DATA_W-1:0]        pwdata;
	logic [DATA_W-1:0]        prdata;
	logic                     pready;

	logic [LEN_W-1:0]  cfg_len = '0;
	logic [DATA_W-1:0] cfg_lo  = '0;
	logic [DATA_W-1:0] cfg_hi  = '0;
	logic [DIG_W-1:0]  digit_buf [MAX_DIGITS];
	logic [VAL_W-1:0]  mag_left;
	int                digit_cnt;

	glyph_t pending_glyphs[$];

	int mismatches      = 0;
	int glyphs_checked  = 0;
	int numbers_sent    = 0;
	int numbers_ignored = 0;
	int reg_writes      = 0;
	int cycle_count     = 0;
	bit burst           = 1'b0;

	radix_integer_formatter_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.value   (value),
		.strobe  (strobe),
		.symbol  (symbol),
		.last    (last),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [SYM_W-1:0] alphabet_symbol(input logic [DIG_W-1:0] k);
		return k[3] ? cfg_hi[k[2:0]*8 +: 8] : cfg_lo[k[2:0]*8 +: 8];
	endfunction

	function automatic bit alphabet_valid();
		logic [SYM_W-1:0] s;
		if (cfg_len < 2 || cfg_len > MAX_RADIX)
			return 1'b0;
		for (int a = 0; a < cfg_len; a++) begin
			s = alphabet_symbol(DIG_W'(a));
			if (s == SYM_PLUS || s == SYM_MINUS)
				return 1'b0;
			for (int b = a + 1; b < cfg_len; b++)
				if (alphabet_symbol(DIG_W'(b)) == s)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void predict_format(input logic [VAL_W-1:0] raw);
		logic neg;
		if (!alphabet_valid())
			return;
		neg = raw[VAL_W-1];
		mag_left = neg ? VAL_W'(0) - raw : raw;
		digit_cnt = 0;
		do begin
			digit_buf[digit_cnt] = DIG_W'(mag_left % cfg_len);
			mag_left = mag_left / cfg_len;
			digit_cnt++;
		end while (mag_left != 0 && digit_cnt < MAX_DIGITS);
		if (neg)
			pending_glyphs.push_back('{SYM_MINUS, 1'b0});
		for (int i = digit_cnt - 1; i >= 0; i--)
			pending_glyphs.push_back('{alphabet_symbol(digit_buf[i]), i == 0});
	endfunction

	function automatic logic [VAL_W-1:0] draw_value(input int radix);
		logic [63:0] p;
		int k;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return 32'h0000_0000;
					1: return 32'h0000_0001;
					2: return 32'hFFFF_FFFF;
					3: return 32'h7FFF_FFFF;
					default: return 32'h8000_0000;
				endcase
			end
			1, 2: begin
				p = $urandom_range(0, 300);
				return $urandom_range(0, 1) ? 32'(64'd0 - p) : p[31:0];
			end
			3: begin
				p = 1;
				k = $urandom_range(1, 31);
				while (k > 0 && p * radix <= 64'h8000_0000) begin
					p = p * radix;
					k--;
				end
				p = p - $urandom_range(0, 1);
				return $urandom_range(0, 1) ? 32'(64'd0 - p) : p[31:0];
			end
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		glyph_t want;
		if (arst_n && strobe) begin
			if (pending_glyphs.size() == 0) begin
				$error("symbol %h (last %b) with no transaction pending", symbol, last);
				mismatches++;
			end else begin
				want = pending_glyphs.pop_front();
				glyphs_checked++;
				if (symbol !== want.sym) begin
					$error("symbol: expected %h, actual %h", want.sym, symbol);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %b, actual %b", want.last, last);
					mismatches++;
				end
			end
		end
	end

	task automatic apb_cycle(input logic [1:0] sel, input logic [DATA_W-1:0] data,
			input bit wr, output logic [DATA_W-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {sel, 3'b000};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
	endtask

	task automatic write_reg(input logic [1:0] sel, input logic [DATA_W-1:0] data);
		logic [DATA_W-1:0] readback;
		logic [DATA_W-1:0] want;
		apb_cycle(sel, data, 1'b1, readback);
		case (sel)
			REG_BASE_LEN: cfg_len = data[LEN_W-1:0];
			REG_ALPHA_LO: cfg_lo = data;
			default: cfg_hi = data;
		endcase
		want = (sel == REG_BASE_LEN) ? DATA_W'(data[LEN_W-1:0]) : data;
		apb_cycle(sel, '0, 1'b0, readback);
		if (readback !== want) begin
			$error("prdata: expected %h, actual %h", want, readback);
			mismatches++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		reg_writes++;
	endtask

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_glyphs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_value(input logic [VAL_W-1:0] v);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		numbers_sent++;
		if (!alphabet_valid())
			numbers_ignored++;
	endtask

	initial begin
		row_t             plan[$];
		row_t             row;
		logic [SYM_W-1:0] tab [16];
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
		logic [VAL_W-1:0] v;
		bit               used [256];
		bit               flawed;
		int               len;
		int               len_field;
		int               a;
		int               b;
		int               count;

		arst_n  = 1'b0;
		start   = 1'b0;
		value   = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;

		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'h0000_0005, 1'b1, ""});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'hFFFF_FFFF, 1'b1, ""});
		plan.push_back('{ROW_WRITE, REG_ALPHA_LO, DEC_LO, 1'b0, ""});
		plan.push_back('{ROW_WRITE, REG_ALPHA_HI, DEC_HI, 1'b0, ""});
		plan.push_back('{ROW_WRITE, REG_BASE_LEN, 64'd10, 1'b0, ""});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'h0000_0000, 1'b1, "0"});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'h7FFF_FFFF, 1'b1, "2147483647"});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'h8000_0000, 1'b1, "-2147483648"});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'hFFFF_FFFF, 1'b1, "-1"});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'd1234, 1'b0, ""});
		plan.push_back('{ROW_WRITE, REG_ALPHA_HI, HEX_HI, 1'b0, ""});
		plan.push_back('{ROW_WRITE, REG_BASE_LEN, 64'd16, 1'b0, ""});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'h8000_0000, 1'b1, "-80000000"});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'h7FFF_FFFF, 1'b1, "7FFFFFFF"});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'hDEAD_BEEF, 1'b0, ""});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'h0F0F_0F0F, 1'b0, ""});
		plan.push_back('{ROW_WRITE, REG_BASE_LEN, 64'hFFFF_FFFF_FFFF_FFE2, 1'b0, ""});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'h8000_0000, 1'b1,
			{"-10000000", "00000000", "00000000", "00000000"}});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'h7FFF_FFFF, 1'b0, ""});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'h0000_0001, 1'b1, "1"});
		plan.push_back('{ROW_WRITE, REG_ALPHA_LO, 64'h0000_0000_0062_6100, 1'b0, ""});
		plan.push_back('{ROW_WRITE, REG_BASE_LEN, 64'd3, 1'b0, ""});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'h0000_0000, 1'b0, ""});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'h0000_0005, 1'b0, ""});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'hFFFF_FFF9, 1'b0, ""});
		plan.push_back('{ROW_WRITE, REG_BASE_LEN, 64'd1, 1'b0, ""});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'h0000_0007, 1'b1, ""});
		plan.push_back('{ROW_WRITE, REG_BASE_LEN, 64'hFFFF_FFFF_FFFF_FFF1, 1'b0, ""});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'h0000_0007, 1'b1, ""});
		plan.push_back('{ROW_WRITE, REG_BASE_LEN, 64'd31, 1'b0, ""});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'h0000_0007, 1'b1, ""});
		plan.push_back('{ROW_WRITE, REG_ALPHA_LO, 64'h0000_0000_3032_3130, 1'b0, ""});
		plan.push_back('{ROW_WRITE, REG_BASE_LEN, 64'd4, 1'b0, ""});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'h0000_0007, 1'b1, ""});
		plan.push_back('{ROW_WRITE, REG_BASE_LEN, 64'd2, 1'b0, ""});
		plan.push_back('{ROW_WRITE, REG_ALPHA_LO, 64'h0000_0000_0000_2B30, 1'b0, ""});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'h0000_0007, 1'b1, ""});
		plan.push_back('{ROW_WRITE, REG_ALPHA_LO, 64'h0000_0000_0000_2D30, 1'b0, ""});
		plan.push_back('{ROW_FORMAT, REG_BASE_LEN, 64'hFFFF_FFFF, 1'b1, ""});

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < plan.size(); r++) begin
			row = plan[r];
			if (row.kind == ROW_WRITE) begin
				settle();
				write_reg(row.sel, row.data);
			end else begin
				send_value(row.data[VAL_W-1:0]);
				if (row.typed) begin
					for (int i = 0; i < row.text.len(); i++)
						pending_glyphs.push_back('{row.text[i], i == row.text.len() - 1});
				end else begin
					predict_format(row.data[VAL_W-1:0]);
				end
			end
		end

		while (numbers_sent - numbers_ignored < NUMBER_GOAL) begin
			flawed = ($urandom_range(0, 9) == 0);
			case ($urandom_range(0, 7))
				0: len = 2;
				1: len = 16;
				default: len = $urandom_range(3, 15);
			endcase
			foreach (used[i])
				used[i] = 1'b0;
			for (int k = 0; k < 16; k++) begin
				tab[k] = $urandom_range(0, 255);
				if (k < len) begin
					while (used[tab[k]] || tab[k] == SYM_PLUS || tab[k] == SYM_MINUS)
						tab[k] = $urandom_range(0, 255);
					used[tab[k]] = 1'b1;
				end
			end
			len_field = len;
			if (flawed) begin
				case ($urandom_range(0, 3))
					0: begin
						len_field = $urandom_range(0, 16);
						if (len_field >= 2)
							len_field = len_field + 15;
					end
					1: begin
						a = $urandom_range(0, len - 2);
						b = $urandom_range(a + 1, len - 1);
						tab[b] = tab[a];
					end
					2: tab[$urandom_range(0, len - 1)] = SYM_PLUS;
					default: tab[$urandom_range(0, len - 1)] = SYM_MINUS;
				endcase
			end
			for (int k = 0; k < 8; k++) begin
				lo[k*8 +: 8] = tab[k];
				hi[k*8 +: 8] = tab[k + 8];
			end

			settle();
			write_reg(REG_BASE_LEN, {$urandom, $urandom} & ~64'h1F | 64'(len_field));
			write_reg(REG_ALPHA_LO, lo);
			write_reg(REG_ALPHA_HI, hi);

			burst = ($urandom_range(0, 3) == 0);
			count = flawed ? 3 : $urandom_range(8, 30);
			repeat (count) begin
				v = draw_value(len);
				send_value(v);
				predict_format(v);
			end
		end

		settle();
		$display("Formatted %0d numbers (%0d under rejected alphabets) after %0d register writes.",
			numbers_sent, numbers_ignored, reg_writes);
		$display("Compared %0d output symbols, %0d mismatches.", glyphs_checked, mismatches);
		if (mismatches == 0 && pending_glyphs.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> files.f
sv/rif_pkg.sv
sv/rif_ctrl.sv
sv/rif_datapath.sv
sv/radix_integer_formatter_unit.sv
sv/rif_checker.sv
bench/radix_integer_formatter_unit_test.sv
